// ----- sv/lut3d_trilinear_color_map_assert.svh -----
// Assertion macros for the 3D LUT color map.
`ifndef LUT3D_TRILINEAR_COLOR_MAP_ASSERT_SVH
`define LUT3D_TRILINEAR_COLOR_MAP_ASSERT_SVH

`ifndef SYNTHESIS
// Condition must never hold at a clock edge outside reset.
`define L3DCM_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) \
        else $error("l3dcm: forbidden condition seen");
// Antecedent implies consequent in the same cycle.
`define L3DCM_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("l3dcm: implication violated");
`else
`define L3DCM_ASSERT_NEVER(lbl, cond)
`define L3DCM_ASSERT_IMPLY(lbl, ante, cons)
`endif

`endif

// ----- sv/l3dcm_pkg.sv -----
package l3dcm_pkg;

    localparam int CFG_W        = 6;
    localparam int DEF_MAX_GRID = 33;
    localparam int QUEUE_DEPTH  = 8;
    localparam int OUT_DEPTH    = 8;
    localparam int ADDR_W       = 16;
    localparam int ADDR_SPAN    = 65536;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] entry_index;
        logic [15:0] entry_red;
        logic [15:0] entry_green;
        logic [15:0] entry_blue;
        logic [7:0]  pixel_red;
        logic [7:0]  pixel_green;
        logic [7:0]  pixel_blue;
        logic [7:0]  pixel_alpha;
        logic        last_pixel;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       out_last;
    } t_out;

    // Work handed from front to back. Index 0 of per-channel arrays is red.
    typedef struct packed {
        logic                         cmd;
        logic                         pass;
        logic                         wr_ok;
        logic [7:0][ADDR_W-1:0]       addr;
        logic [2:0][8:0]              w;
        logic [2:0][15:0]             data;
        logic [7:0]                   alpha;
        logic                         last;
    } t_job;

endpackage

// ----- sv/l3dcm_fifo.sv -----
module l3dcm_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  T                           i_data,
    input  logic                       i_pop,
    output T                           o_head,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH+1);

    T                r_mem [DEPTH];
    logic [PW-1:0]   r_wp;
    logic [PW-1:0]   r_rp;
    logic [CW-1:0]   r_cnt;
    logic            do_pop;

    assign do_pop  = i_pop && (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(do_pop);
        end
    end

endmodule

// ----- sv/l3dcm_front.sv -----
module l3dcm_front #(
    parameter int MAX_GRID_POINTS = l3dcm_pkg::DEF_MAX_GRID
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  l3dcm_pkg::t_in                 i_item,
    input  logic [l3dcm_pkg::CFG_W-1:0]    i_grid_n,
    input  logic [2*l3dcm_pkg::CFG_W-1:0]  i_grid_nn,
    input  logic                           i_q_pop,
    output logic                           o_q_push,
    output l3dcm_pkg::t_job                o_q_job
);

    localparam int NW          = l3dcm_pkg::CFG_W;
    localparam int PW          = 8 + NW;
    localparam int AW          = l3dcm_pkg::ADDR_W;
    localparam int TABLE_DEPTH = MAX_GRID_POINTS * MAX_GRID_POINTS * MAX_GRID_POINTS;
    localparam int CNT_W       = $clog2(l3dcm_pkg::QUEUE_DEPTH + 1);

    logic              accept;
    logic [CNT_W-1:0]  r_cnt;
    logic [3:0]        r_vld;
    logic [2:0][7:0]   in_pix;
    logic [NW-1:0]     n_m1;
    logic [NW-1:0]     n_m2;

    l3dcm_pkg::t_in    r1_item, r2_item, r3_item, r4_item;
    logic              r1_wr_ok, r2_wr_ok, r3_wr_ok, r4_wr_ok;
    logic [2:0][PW-1:0] r1_p;
    logic [2:0][NW-1:0] r2_base, r3_base;
    logic [2:0][7:0]    r2_rem;
    logic [2:0][8:0]    r3_w, r4_w;
    logic [NW-1:0]      r4_br;
    logic [2*NW-1:0]    r4_g;
    logic [3*NW-1:0]    r4_b;

    logic [2:0][PW-1:0] n_p;
    logic [2:0][NW-1:0] n_base2, n_base3;
    logic [2:0][7:0]    n_rem;
    logic [2:0][8:0]    n_w;
    logic [AW-1:0]      addr0;

    assign accept    = i_push && !o_full;
    assign o_full    = (r_cnt >= CNT_W'(l3dcm_pkg::QUEUE_DEPTH));
    assign in_pix[0] = i_item.pixel_red;
    assign in_pix[1] = i_item.pixel_green;
    assign in_pix[2] = i_item.pixel_blue;
    assign n_m1      = i_grid_n - 1'b1;
    assign n_m2      = i_grid_n - NW'(2);

    // grid position, quotient/remainder by 255, weight rounding
    always_comb begin
        logic [PW:0] s2;
        logic [15:0] x;
        logic [16:0] s3;
        for (int c = 0; c < 3; c++) begin
            n_p[c] = PW'(in_pix[c]) * PW'(n_m1);
            s2 = {1'b0, r1_p[c]} + (PW+1)'(r1_p[c] >> 8) + (PW+1)'(1);
            n_base2[c] = s2[NW+7:8];
            n_rem[c] = 8'(r1_p[c] - (PW'(n_base2[c]) << 8) + PW'(n_base2[c]));
            x = {r2_rem[c], 8'h7F};
            s3 = {1'b0, x} + 17'(x >> 8) + 17'd1;
            if (r2_base[c] >= n_m1) begin
                n_base3[c] = n_m2;
                n_w[c]     = 9'd256;
            end else begin
                n_base3[c] = r2_base[c];
                n_w[c]     = s3[16:8];
            end
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        r1_item  <= i_item;
        r1_wr_ok <= (32'(i_item.entry_index) < 32'(TABLE_DEPTH));
        r1_p     <= n_p;
        r2_item  <= r1_item;
        r2_wr_ok <= r1_wr_ok;
        r2_base  <= n_base2;
        r2_rem   <= n_rem;
        r3_item  <= r2_item;
        r3_wr_ok <= r2_wr_ok;
        r3_base  <= n_base3;
        r3_w     <= n_w;
        r4_item  <= r3_item;
        r4_wr_ok <= r3_wr_ok;
        r4_w     <= r3_w;
        r4_br    <= r3_base[0];
        r4_g     <= (2*NW)'(r3_base[1]) * (2*NW)'(i_grid_n);
        r4_b     <= (3*NW)'(r3_base[2]) * (3*NW)'(i_grid_nn);
    end

    // occupancy of front stages plus queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_cnt <= '0;
        end else begin
            r_vld <= {r_vld[2:0], accept};
            r_cnt <= r_cnt + CNT_W'(accept) - CNT_W'(i_q_pop);
        end
    end

    // corner addresses and job assembly
    assign addr0 = AW'(r4_br) + AW'(r4_g) + AW'(r4_b);

    always_comb begin
        o_q_job.cmd   = r4_item.cmd;
        o_q_job.pass  = (i_grid_n < NW'(2));
        o_q_job.wr_ok = r4_wr_ok;
        for (int k = 0; k < 8; k++) begin
            o_q_job.addr[k] = addr0 + AW'(k & 1)
                            + (((k & 2) != 0) ? AW'(i_grid_n) : '0)
                            + (((k & 4) != 0) ? AW'(i_grid_nn) : '0);
        end
        o_q_job.w = r4_w;
        if (r4_item.cmd == l3dcm_pkg::CMD_LOAD) begin
            o_q_job.addr[0] = AW'(r4_item.entry_index);
            o_q_job.data[0] = r4_item.entry_red;
            o_q_job.data[1] = r4_item.entry_green;
            o_q_job.data[2] = r4_item.entry_blue;
        end else begin
            o_q_job.data[0] = {8'd0, r4_item.pixel_red};
            o_q_job.data[1] = {8'd0, r4_item.pixel_green};
            o_q_job.data[2] = {8'd0, r4_item.pixel_blue};
        end
        o_q_job.alpha = r4_item.pixel_alpha;
        o_q_job.last  = r4_item.last_pixel;
    end

    assign o_q_push = r_vld[3];

endmodule

// ----- sv/l3dcm_back.sv -----
module l3dcm_back #(
    parameter int MAX_GRID_POINTS = l3dcm_pkg::DEF_MAX_GRID
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  l3dcm_pkg::t_job  i_job,
    input  logic             i_q_empty,
    output logic             o_q_pop,
    input  logic             i_res_pop,
    output logic             o_res_push,
    output l3dcm_pkg::t_out  o_res
);

    localparam int AW        = l3dcm_pkg::ADDR_W;
    localparam int FULL_D    = MAX_GRID_POINTS * MAX_GRID_POINTS * MAX_GRID_POINTS;
    localparam int MEM_DEPTH = (FULL_D < l3dcm_pkg::ADDR_SPAN) ? FULL_D : l3dcm_pkg::ADDR_SPAN;
    localparam int MW        = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
    localparam int CNT_W     = $clog2(l3dcm_pkg::OUT_DEPTH + 1);

    // four banks of the full table, two read ports each: eight corners per cycle
    logic [2:0][15:0] r_bank0 [MEM_DEPTH];
    logic [2:0][15:0] r_bank1 [MEM_DEPTH];
    logic [2:0][15:0] r_bank2 [MEM_DEPTH];
    logic [2:0][15:0] r_bank3 [MEM_DEPTH];

    logic               pixel_head;
    logic               do_write;
    logic [CNT_W-1:0]   r_pend;
    logic [5:0]         r_vld;
    logic [7:0][MW-1:0] rd_addr;

    logic [7:0][2:0][15:0] r1_rd, r2_rd;
    logic [3:0][16:0]      r1_wrg;
    logic [8:0]            r1_wb;
    logic [7:0][24:0]      r2_w8;
    logic [7:0][2:0][39:0] r3_prod;
    logic [3:0][2:0][40:0] r4_sum;
    logic [1:0][2:0][41:0] r5_sum;
    logic [2:0][42:0]      r6_sum;
    logic [5:0]            r_pass;
    logic [5:0][2:0][7:0]  r_pix;
    logic [5:0][7:0]       r_alpha;
    logic [5:0]            r_last;

    logic [3:0][16:0]      n_wrg;
    logic [7:0][24:0]      n_w8;

    assign pixel_head = (i_job.cmd == l3dcm_pkg::CMD_PIXEL);
    assign o_q_pop    = !i_q_empty &&
                        (!pixel_head || (r_pend < CNT_W'(l3dcm_pkg::OUT_DEPTH)));
    assign do_write   = o_q_pop && !pixel_head && i_job.wr_ok;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            rd_addr[k] = MW'(i_job.addr[k]);
        end
    end

    // table write and corner reads
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_bank0[rd_addr[0]] <= i_job.data;
            r_bank1[rd_addr[0]] <= i_job.data;
            r_bank2[rd_addr[0]] <= i_job.data;
            r_bank3[rd_addr[0]] <= i_job.data;
        end
        r1_rd[0] <= r_bank0[rd_addr[0]];
        r1_rd[1] <= r_bank0[rd_addr[1]];
        r1_rd[2] <= r_bank1[rd_addr[2]];
        r1_rd[3] <= r_bank1[rd_addr[3]];
        r1_rd[4] <= r_bank2[rd_addr[4]];
        r1_rd[5] <= r_bank2[rd_addr[5]];
        r1_rd[6] <= r_bank3[rd_addr[6]];
        r1_rd[7] <= r_bank3[rd_addr[7]];
    end

    // corner weights: red x green, then times blue
    always_comb begin
        logic [8:0] a, b, d;
        for (int k = 0; k < 4; k++) begin
            a = ((k & 1) != 0) ? i_job.w[0] : 9'd256 - i_job.w[0];
            b = ((k & 2) != 0) ? i_job.w[1] : 9'd256 - i_job.w[1];
            n_wrg[k] = 17'(a) * 17'(b);
        end
        for (int k = 0; k < 8; k++) begin
            d = ((k & 4) != 0) ? r1_wb : 9'd256 - r1_wb;
            n_w8[k] = 25'(26'(r1_wrg[k & 3]) * 26'(d));
        end
    end

    // blend pipeline
    always_ff @(posedge i_clk) begin
        r1_wrg <= n_wrg;
        r1_wb  <= i_job.w[2];
        r2_rd  <= r1_rd;
        r2_w8  <= n_w8;
        for (int k = 0; k < 8; k++) begin
            for (int c = 0; c < 3; c++) begin
                r3_prod[k][c] <= 40'(41'(r2_rd[k][c]) * 41'(r2_w8[k]));
            end
        end
        for (int c = 0; c < 3; c++) begin
            for (int j = 0; j < 4; j++) begin
                r4_sum[j][c] <= 41'(r3_prod[2*j][c]) + 41'(r3_prod[2*j+1][c]);
            end
            for (int j = 0; j < 2; j++) begin
                r5_sum[j][c] <= 42'(r4_sum[2*j][c]) + 42'(r4_sum[2*j+1][c]);
            end
            r6_sum[c] <= 43'(r5_sum[0][c]) + 43'(r5_sum[1][c]);
        end
        // sideband rides alongside
        r_pass[0]  <= i_job.pass;
        r_pix[0]   <= {i_job.data[2][7:0], i_job.data[1][7:0], i_job.data[0][7:0]};
        r_alpha[0] <= i_job.alpha;
        r_last[0]  <= i_job.last;
        for (int s = 1; s < 6; s++) begin
            r_pass[s]  <= r_pass[s-1];
            r_pix[s]   <= r_pix[s-1];
            r_alpha[s] <= r_alpha[s-1];
            r_last[s]  <= r_last[s-1];
        end
    end

    // in-flight pixels plus waiting results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_pend <= '0;
        end else begin
            r_vld  <= {r_vld[4:0], o_q_pop && pixel_head};
            r_pend <= r_pend + CNT_W'(o_q_pop && pixel_head) - CNT_W'(i_res_pop);
        end
    end

    // scale by 255, round half up, saturate
    always_comb begin
        logic [51:0] t;
        logic [2:0][7:0] ch;
        for (int c = 0; c < 3; c++) begin
            t = (52'(r6_sum[c]) << 8) - 52'(r6_sum[c]) + (52'd1 << 39);
            ch[c] = (t[51:40] > 12'd255) ? 8'd255 : t[47:40];
        end
        if (r_pass[5]) begin
            ch = r_pix[5];
        end
        o_res.out_red   = ch[0];
        o_res.out_green = ch[1];
        o_res.out_blue  = ch[2];
        o_res.out_alpha = r_alpha[5];
        o_res.out_last  = r_last[5];
    end

    assign o_res_push = r_vld[5];

endmodule

// ----- sv/lut3d_trilinear_color_map.sv -----
// An accepted pixel beat passes the front stages, job queue, table read (8 ports
//   in 4 banks), 5 blend stages and result queue before its result reaches the head.
// Throughput: one beat per cycle, pixel or table load, while full is low.
// Reset: synchronous, active low; clears queues, counters and grid size (pass-through).
//   The table itself is not cleared and holds garbage until loaded.
module lut3d_trilinear_color_map #(
    parameter int MAX_GRID_POINTS = l3dcm_pkg::DEF_MAX_GRID
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         push,
    output logic                         full,
    input  l3dcm_pkg::t_in               i_item,
    output logic                         empty,
    input  logic                         pop,
    output l3dcm_pkg::t_out              o_result,
    input  logic                         i_cfg_we,
    input  logic [l3dcm_pkg::CFG_W-1:0]  i_cfg_data
);

`include "lut3d_trilinear_color_map_assert.svh"

    localparam int NW  = l3dcm_pkg::CFG_W;
    localparam int QCW = $clog2(l3dcm_pkg::QUEUE_DEPTH + 1);
    localparam int OCW = $clog2(l3dcm_pkg::OUT_DEPTH + 1);

    logic [NW-1:0]    r_grid_n;
    logic [2*NW-1:0]  r_grid_nn;
    logic [NW-1:0]    cfg_n;

    logic             q_push, q_pop, q_empty;
    l3dcm_pkg::t_job  q_in, q_head;
    logic [QCW-1:0]   q_count;
    logic             res_push;
    l3dcm_pkg::t_out  res_in;
    logic [OCW-1:0]   res_count;

    // grid size register, limited to the table's extent
    assign cfg_n = (32'(i_cfg_data) > 32'(MAX_GRID_POINTS)) ? NW'(MAX_GRID_POINTS) : i_cfg_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_n  <= '0;
            r_grid_nn <= '0;
        end else if (i_cfg_we) begin
            r_grid_n  <= cfg_n;
            r_grid_nn <= (2*NW)'(cfg_n) * (2*NW)'(cfg_n);
        end
    end

    l3dcm_front #(.MAX_GRID_POINTS(MAX_GRID_POINTS)) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_item    (i_item),
        .i_grid_n  (r_grid_n),
        .i_grid_nn (r_grid_nn),
        .i_q_pop   (q_pop),
        .o_q_push  (q_push),
        .o_q_job   (q_in)
    );

    l3dcm_fifo #(.T(l3dcm_pkg::t_job), .DEPTH(l3dcm_pkg::QUEUE_DEPTH)) u_job_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    l3dcm_back #(.MAX_GRID_POINTS(MAX_GRID_POINTS)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_job      (q_head),
        .i_q_empty  (q_empty),
        .o_q_pop    (q_pop),
        .i_res_pop  (pop && !empty),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    l3dcm_fifo #(.T(l3dcm_pkg::t_out), .DEPTH(l3dcm_pkg::OUT_DEPTH)) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .i_pop   (pop),
        .o_head  (o_result),
        .o_empty (empty),
        .o_count (res_count)
    );

    // credit schemes must keep both queues from overflowing
    `L3DCM_ASSERT_NEVER(a_job_q_overflow, q_push && (q_count == QCW'(l3dcm_pkg::QUEUE_DEPTH)))
    `L3DCM_ASSERT_NEVER(a_res_q_overflow, res_push && (res_count == OCW'(l3dcm_pkg::OUT_DEPTH)))
    `L3DCM_ASSERT_IMPLY(a_pop_needs_head, q_pop, !q_empty)

endmodule

// ----- tb/sv/lut3d_trilinear_color_map_tb.sv -----
module lut3d_trilinear_color_map_tb;

    localparam int GRID  = l3dcm_pkg::DEF_MAX_GRID;
    localparam int DEPTH = GRID * GRID * GRID;
    localparam int LIMIT = 4000000;
    localparam int DRAIN = 30;
    localparam int IN_W  = $bits(l3dcm_pkg::t_in);
    localparam int CW    = l3dcm_pkg::CFG_W;

    logic            i_clk;
    logic            i_rst_n;
    logic            push;
    logic            full;
    l3dcm_pkg::t_in  i_item;
    logic            empty;
    logic            pop;
    l3dcm_pkg::t_out o_result;
    logic            i_cfg_we;
    logic [CW-1:0]   i_cfg_data;

    lut3d_trilinear_color_map uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_item     (i_item),
        .empty      (empty),
        .pop        (pop),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    // Shadow of the color table and grid size
    logic [15:0] shadow_r [0:DEPTH-1];
    logic [15:0] shadow_g [0:DEPTH-1];
    logic [15:0] shadow_b [0:DEPTH-1];
    // Entries that some queued load will write before they are read
    bit          planned  [0:DEPTH-1];
    int unsigned grid_size;

    l3dcm_pkg::t_in  beats_to_send [$];
    l3dcm_pkg::t_out expected_pix [$];
    int   gap_max;
    int   gap_left;
    int   stall_left;
    int   hold_left;
    bit   hold_req;
    bit   hold_done;
    int   fail_count;
    int   cycle_count;

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    task automatic report(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        fail_count++;
    endtask

    // Channel to grid base and 0..256 blend weight
    function automatic void split_chan(input int unsigned v, input int unsigned n,
                                       output int unsigned base,
                                       output int unsigned wgt);
        int unsigned p;
        int unsigned rem;
        p    = v * (n - 1);
        base = p / 255;
        rem  = p % 255;
        wgt  = (rem * 256 + 127) / 255;
        if (base >= n - 1) begin
            base = n - 2;
            wgt  = 256;
        end
    endfunction

    function automatic logic [7:0] round_u8(input longint unsigned s);
        longint unsigned o;
        o = (s * 255 + (64'd1 << 39)) >> 40;
        return (o > 255) ? 8'd255 : o[7:0];
    endfunction

    // Apply one accepted beat; pixels queue their mapped color
    function automatic void map_pixel(input l3dcm_pkg::t_in b);
        l3dcm_pkg::t_out res;
        int unsigned     n, br, bg, bb, wr, wg, wb, idx, dr, dg, db;
        longint unsigned sr, sg, sb, wt;
        sr = 0;
        sg = 0;
        sb = 0;
        if (b.cmd == l3dcm_pkg::CMD_LOAD) begin
            if (b.entry_index < DEPTH) begin
                shadow_r[b.entry_index] = b.entry_red;
                shadow_g[b.entry_index] = b.entry_green;
                shadow_b[b.entry_index] = b.entry_blue;
            end
            return;
        end
        res.out_alpha = b.pixel_alpha;
        res.out_last  = b.last_pixel;
        n = (grid_size > GRID) ? GRID : grid_size;
        if (n < 2) begin
            res.out_red   = b.pixel_red;
            res.out_green = b.pixel_green;
            res.out_blue  = b.pixel_blue;
        end else begin
            split_chan(b.pixel_red, n, br, wr);
            split_chan(b.pixel_green, n, bg, wg);
            split_chan(b.pixel_blue, n, bb, wb);
            for (int k = 0; k < 8; k++) begin
                dr  = k & 1;
                dg  = (k >> 1) & 1;
                db  = (k >> 2) & 1;
                idx = (br + dr) + (bg + dg) * n + (bb + db) * n * n;
                wt  = longint'(dr ? wr : 256 - wr) * longint'(dg ? wg : 256 - wg)
                    * longint'(db ? wb : 256 - wb);
                sr += longint'(shadow_r[idx]) * wt;
                sg += longint'(shadow_g[idx]) * wt;
                sb += longint'(shadow_b[idx]) * wt;
            end
            res.out_red   = round_u8(sr);
            res.out_green = round_u8(sg);
            res.out_blue  = round_u8(sb);
        end
        expected_pix.push_back(res);
    endfunction

    // Driver: offers queued beats with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push     <= 1'b0;
            i_item   <= '0;
            gap_left <= 0;
        end else begin
            if (push && !full)
                map_pixel(i_item);
            if (!(push && full)) begin
                if (gap_left != 0) begin
                    push     <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (beats_to_send.size() != 0) begin
                    i_item   <= beats_to_send.pop_front();
                    push     <= 1'b1;
                    gap_left <= (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks results, random stalls, one long hold-off
    always @(posedge i_clk) begin
        l3dcm_pkg::t_out want;
        int              s;
        if (!i_rst_n) begin
            pop        <= 1'b0;
            stall_left <= 0;
            hold_left  <= 0;
            hold_done  <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_pix.size() == 0) begin
                    report("unexpected result", 1, 0);
                end else begin
                    want = expected_pix.pop_front();
                    if (o_result.out_red !== want.out_red)
                        report("red", o_result.out_red, want.out_red);
                    if (o_result.out_green !== want.out_green)
                        report("green", o_result.out_green, want.out_green);
                    if (o_result.out_blue !== want.out_blue)
                        report("blue", o_result.out_blue, want.out_blue);
                    if (o_result.out_alpha !== want.out_alpha)
                        report("alpha", o_result.out_alpha, want.out_alpha);
                    if (o_result.out_last !== want.out_last)
                        report("last", o_result.out_last, want.out_last);
                end
            end
            if (hold_req && !hold_done) begin
                hold_done <= 1'b1;
                hold_left <= 400;
                pop       <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else if (pop && !empty) begin
                s = (gap_max == 0) ? 0 : $urandom_range(0, 16);
                stall_left <= s;
                pop        <= (s == 0);
            end else if (stall_left != 0) begin
                stall_left <= stall_left - 1;
                pop        <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic l3dcm_pkg::t_in pixel_beat(input int r, input int g, input int b,
                                                  input int a, input bit last);
        l3dcm_pkg::t_in t;
        t = IN_W'({$urandom, $urandom, $urandom, $urandom});
        t.cmd         = l3dcm_pkg::CMD_PIXEL;
        t.pixel_red   = 8'(r);
        t.pixel_green = 8'(g);
        t.pixel_blue  = 8'(b);
        t.pixel_alpha = 8'(a);
        t.last_pixel  = last;
        return t;
    endfunction

    function automatic int rand_chan();
        case ($urandom_range(0, 7))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic l3dcm_pkg::t_in load_beat(input int idx);
        l3dcm_pkg::t_in t;
        t = IN_W'({$urandom, $urandom, $urandom, $urandom});
        t.cmd         = l3dcm_pkg::CMD_LOAD;
        t.entry_index = 16'(idx);
        if ($urandom_range(0, 9) == 0)
            t.entry_red = '1;
        if ($urandom_range(0, 9) == 0)
            t.entry_blue = '0;
        return t;
    endfunction

    // Queue a pixel, preceded by loads of any corner not yet written; returns beats queued
    function automatic int add_pixel(input int r, input int g, input int b,
                                     input int a, input bit last);
        int unsigned n, br, bg, bb, wr, wg, wb, idx;
        int          pushed;
        pushed = 1;
        n = (grid_size > GRID) ? GRID : grid_size;
        if (n >= 2) begin
            split_chan(r, n, br, wr);
            split_chan(g, n, bg, wg);
            split_chan(b, n, bb, wb);
            for (int k = 0; k < 8; k++) begin
                idx = (br + (k & 1)) + (bg + ((k >> 1) & 1)) * n
                    + (bb + ((k >> 2) & 1)) * n * n;
                if (!planned[idx]) begin
                    planned[idx] = 1'b1;
                    beats_to_send.push_back(load_beat(idx));
                    pushed++;
                end
            end
        end
        beats_to_send.push_back(pixel_beat(r, g, b, a, last));
        return pushed;
    endfunction

    // Wait until every beat is in and every result is out
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (beats_to_send.size() != 0 || push || expected_pix.size() != 0);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic set_grid(input int v);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= CW'(v);
        grid_size = v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic random_mix(input int count);
        int i;
        int idx;
        i = 0;
        while (i < count) begin
            if ($urandom_range(0, 4) == 0) begin
                idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, DEPTH - 1);
                if (idx < DEPTH)
                    planned[idx] = 1'b1;
                beats_to_send.push_back(load_beat(idx));
                i++;
            end else begin
                i += add_pixel(rand_chan(), rand_chan(), rand_chan(),
                               $urandom_range(0, 255), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    task automatic corner_pixels();
        void'(add_pixel(0, 0, 0, 0, 1'b0));
        void'(add_pixel(255, 255, 255, 255, 1'b1));
        void'(add_pixel(255, 0, 128, 7, 1'b0));
        void'(add_pixel(1, 254, 127, 200, 1'b1));
        void'(add_pixel(128, 128, 128, 128, 1'b0));
    endtask

    initial begin
        int sizes [10] = '{1, 2, 3, 5, 9, 17, 33, 34, 63, 0};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        gap_max     = 16;
        hold_req    = 1'b0;
        fail_count  = 0;
        cycle_count = 0;
        grid_size   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Pass-through after reset, and loads outside the table
        corner_pixels();
        beats_to_send.push_back(load_beat(DEPTH));
        beats_to_send.push_back(load_beat(65535));
        wait_idle();

        foreach (sizes[p]) begin
            set_grid(sizes[p]);
            if (sizes[p] == 2 || sizes[p] == 33)
                corner_pixels();
            // Back-to-back beats against a long receiver hold-off
            if (p == 4) begin
                gap_max  = 0;
                hold_req = 1'b1;
            end
            random_mix(175);
            wait_idle();
            gap_max = 16;
        end

        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/l3dcm_pkg.sv
sv/l3dcm_fifo.sv
sv/l3dcm_front.sv
sv/l3dcm_back.sv
sv/lut3d_trilinear_color_map.sv
tb/sv/lut3d_trilinear_color_map_tb.sv
